### design/lkvc_pkg.sv
package lkvc_pkg;

   localparam int KEY_W   = 64;
   localparam int VALUE_W = 64;
   localparam int OP_W    = 3;
   localparam int STAT_W  = 3;
   localparam int CAP_W   = 7;
   localparam int FILL_W  = 7;

   // opcodes
   localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
   localparam logic [OP_W-1:0] OP_GET    = 3'd1;
   localparam logic [OP_W-1:0] OP_PIN    = 3'd2;
   localparam logic [OP_W-1:0] OP_UNPIN  = 3'd3;
   localparam logic [OP_W-1:0] OP_REMOVE = 3'd4;
   localparam logic [OP_W-1:0] OP_EVICT  = 3'd5;

   // status codes
   localparam logic [STAT_W-1:0] STAT_MISS    = 3'd0;
   localparam logic [STAT_W-1:0] STAT_HIT     = 3'd1;
   localparam logic [STAT_W-1:0] STAT_BUSY    = 3'd2;
   localparam logic [STAT_W-1:0] STAT_EVICTED = 3'd3;
   localparam logic [STAT_W-1:0] STAT_DUP     = 3'd4;
   localparam logic [STAT_W-1:0] STAT_EMPTY   = 3'd5;

   localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

   typedef struct packed {
      logic [OP_W-1:0]    opcode;
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [STAT_W-1:0]  status;
      logic [KEY_W-1:0]   out_key;
      logic [VALUE_W-1:0] out_value;
      logic [FILL_W-1:0]  fill_count;
   } rsp_type;

endpackage

### design/lkvc_store.sv
module lkvc_store #(
   parameter int ENTRIES = 64,
   parameter int AW      = 6,
   parameter int MW      = 8
) (
   input  logic                         clock,
   input  logic                         rd_en,
   input  logic [AW-1:0]                rd_addr,
   output logic [lkvc_pkg::KEY_W-1:0]   rd_key,
   output logic [lkvc_pkg::VALUE_W-1:0] rd_value,
   output logic [MW-1:0]                rd_meta,
   input  logic                         wr_kv_en,
   input  logic                         wr_meta_en,
   input  logic [AW-1:0]                wr_addr,
   input  logic [lkvc_pkg::KEY_W-1:0]   wr_key,
   input  logic [lkvc_pkg::VALUE_W-1:0] wr_value,
   input  logic [MW-1:0]                wr_meta
);

   logic [lkvc_pkg::KEY_W-1:0]   key_mem   [ENTRIES];
   logic [lkvc_pkg::VALUE_W-1:0] value_mem [ENTRIES];
   logic [MW-1:0]                meta_mem  [ENTRIES];

   // meta word: valid, pinned, recency rank
   always_ff @(posedge clock) begin
      if (wr_kv_en) begin
         key_mem[wr_addr]   <= wr_key;
         value_mem[wr_addr] <= wr_value;
      end
      if (wr_meta_en) begin
         meta_mem[wr_addr] <= wr_meta;
      end
      if (rd_en) begin
         rd_key   <= key_mem[rd_addr];
         rd_value <= value_mem[rd_addr];
         rd_meta  <= meta_mem[rd_addr];
      end
   end

endmodule

### design/lru_key_value_cache_core.sv
// LRU key-value cache: holds up to ENTRIES 64-bit key/value pairs in
// least-recently-used order, each with a pin mark, and answers one request at a
// time with exactly one response. Keys, values and a meta word (valid, pinned,
// recency rank) live in single-port-read memories; a small sequencer drives one
// shared compare/decrement unit over them. A request passes through these steps
// from one acceptance to the next: the accept step, a lookup scan over all
// entries, a decision step, a rank-update sweep over all entries when recency
// changes (get, pin, remove, evict, duplicate insert, insert with eviction), a
// write step when an entry is written, and a step that posts the response.
// Plain insert and unpin skip the sweep; misses and busy outcomes skip both the
// sweep and the write. The post step stalls while an earlier response still
// waits on rsp_ready. After reset a clearing pass over all entries wipes the
// meta memory before the first request is taken; capacity writes are taken at
// any time.
// A new request is taken while the previous response still waits on rsp_ready.
module lru_key_value_cache_core #(
   parameter int ENTRIES = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  lkvc_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output lkvc_pkg::rsp_type                   rsp_data,
   input  logic                                csr_we,
   input  logic [lkvc_pkg::CAP_W-1:0]          csr_wdata
);

   localparam int AW = $clog2(ENTRIES);
   localparam int OW = $clog2(ENTRIES + 1);
   localparam int LW = (OW > lkvc_pkg::CAP_W) ? OW : lkvc_pkg::CAP_W;
   localparam int MW = AW + 2;
   localparam logic [AW-1:0] LAST_ADDR = AW'(ENTRIES - 1);
   localparam logic [AW:0]   CNT_END   = (AW + 1)'(ENTRIES);

   typedef enum logic [6:0] {
      ST_CLEAR  = 7'b0000001,
      ST_IDLE   = 7'b0000010,
      ST_SCAN   = 7'b0000100,
      ST_DECIDE = 7'b0001000,
      ST_SWEEP  = 7'b0010000,
      ST_FINAL  = 7'b0100000,
      ST_DONE   = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   lkvc_pkg::req_type req_ff, req_in;
   lkvc_pkg::rsp_type rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [lkvc_pkg::CAP_W-1:0] cap_ff, cap_in;
   logic [OW-1:0]     occ_ff, occ_in;
   logic [AW:0]       cnt_ff, cnt_in;
   logic              rv_ff, rv_in;
   logic [AW-1:0]     ra_ff, ra_in;

   // lookup results
   logic                               m_found_ff, m_found_in;
   logic [AW-1:0]                      m_slot_ff, m_slot_in;
   logic                               m_pin_ff, m_pin_in;
   logic [AW-1:0]                      m_rank_ff, m_rank_in;
   logic [lkvc_pkg::VALUE_W-1:0]       m_val_ff, m_val_in;
   logic                               o_found_ff, o_found_in;
   logic [AW-1:0]                      o_slot_ff, o_slot_in;
   logic                               o_pin_ff, o_pin_in;
   logic [lkvc_pkg::KEY_W-1:0]         o_key_ff, o_key_in;
   logic [lkvc_pkg::VALUE_W-1:0]       o_val_ff, o_val_in;
   logic                               f_found_ff, f_found_in;
   logic [AW-1:0]                      f_slot_ff, f_slot_in;

   // decision
   logic [lkvc_pkg::STAT_W-1:0]        st_ff, st_in;
   logic [lkvc_pkg::KEY_W-1:0]         ok_ff, ok_in;
   logic [lkvc_pkg::VALUE_W-1:0]       ov_ff, ov_in;
   logic [OW-1:0]                      occ_nx_ff, occ_nx_in;
   logic                               sw_ff, sw_in;
   logic [AW-1:0]                      sw_tgt_ff, sw_tgt_in;
   logic [MW-1:0]                      sw_meta_ff, sw_meta_in;
   logic [AW-1:0]                      sw_r_ff, sw_r_in;
   logic                               fin_ff, fin_in;
   logic                               fin_kv_ff, fin_kv_in;
   logic [AW-1:0]                      fin_slot_ff, fin_slot_in;
   logic [MW-1:0]                      fin_meta_ff, fin_meta_in;

   // memory ports
   logic                               rd_en;
   logic [AW-1:0]                      rd_addr;
   logic [lkvc_pkg::KEY_W-1:0]         rd_key;
   logic [lkvc_pkg::VALUE_W-1:0]       rd_value;
   logic [MW-1:0]                      rd_meta;
   logic                               wr_kv_en;
   logic                               wr_meta_en;
   logic [AW-1:0]                      wr_addr;
   logic [MW-1:0]                      wr_meta;

   // shared compare unit on the word coming out of memory
   logic          rd_v, rd_p;
   logic [AW-1:0] rd_rank;
   logic          key_hit, is_oldest, is_free, rank_above;
   logic          full;
   logic [LW-1:0] cap_nz, cap_eff;
   logic          rsp_load;

   lkvc_store #(.ENTRIES(ENTRIES), .AW(AW), .MW(MW)) u_store (
      .clock      (clock),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_key     (rd_key),
      .rd_value   (rd_value),
      .rd_meta    (rd_meta),
      .wr_kv_en   (wr_kv_en),
      .wr_meta_en (wr_meta_en),
      .wr_addr    (wr_addr),
      .wr_key     (req_ff.key),
      .wr_value   (req_ff.value),
      .wr_meta    (wr_meta)
   );

   assign rd_v       = rd_meta[MW-1];
   assign rd_p       = rd_meta[MW-2];
   assign rd_rank    = rd_meta[AW-1:0];
   assign key_hit    = rd_v && (rd_key == req_ff.key);
   assign is_oldest  = rd_v && (rd_rank == '0);
   assign is_free    = !rd_v;
   assign rank_above = rd_v && (rd_rank > sw_r_ff);

   // clamp capacity into 1..ENTRIES
   assign cap_nz  = (cap_ff == '0) ? LW'(1) : LW'(cap_ff);
   assign cap_eff = (cap_nz > LW'(ENTRIES)) ? LW'(ENTRIES) : cap_nz;
   assign full    = LW'(occ_ff) >= cap_eff;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign rsp_load  = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   // memory port control
   always_comb begin
      rd_en      = 1'b0;
      rd_addr    = cnt_ff[AW-1:0];
      wr_kv_en   = 1'b0;
      wr_meta_en = 1'b0;
      wr_addr    = cnt_ff[AW-1:0];
      wr_meta    = '0;
      case (state_ff)
         ST_CLEAR: begin
            wr_meta_en = 1'b1;
         end
         ST_SCAN: begin
            rd_en = (cnt_ff != CNT_END);
         end
         ST_SWEEP: begin
            rd_en   = (cnt_ff != CNT_END);
            wr_addr = ra_ff;
            if (rv_ff) begin
               // drop or retarget the chosen entry, close the rank gap elsewhere
               if (ra_ff == sw_tgt_ff) begin
                  wr_meta_en = 1'b1;
                  wr_meta    = sw_meta_ff;
               end else if (rank_above) begin
                  wr_meta_en = 1'b1;
                  wr_meta    = {rd_v, rd_p, rd_rank - AW'(1)};
               end
            end
         end
         ST_FINAL: begin
            wr_meta_en = 1'b1;
            wr_kv_en   = fin_kv_ff;
            wr_addr    = fin_slot_ff;
            wr_meta    = fin_meta_ff;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      cap_in       = csr_we ? csr_wdata : cap_ff;
      occ_in       = occ_ff;
      cnt_in       = cnt_ff;
      rv_in        = rd_en;
      ra_in        = rd_addr;
      m_found_in   = m_found_ff;
      m_slot_in    = m_slot_ff;
      m_pin_in     = m_pin_ff;
      m_rank_in    = m_rank_ff;
      m_val_in     = m_val_ff;
      o_found_in   = o_found_ff;
      o_slot_in    = o_slot_ff;
      o_pin_in     = o_pin_ff;
      o_key_in     = o_key_ff;
      o_val_in     = o_val_ff;
      f_found_in   = f_found_ff;
      f_slot_in    = f_slot_ff;
      st_in        = st_ff;
      ok_in        = ok_ff;
      ov_in        = ov_ff;
      occ_nx_in    = occ_nx_ff;
      sw_in        = sw_ff;
      sw_tgt_in    = sw_tgt_ff;
      sw_meta_in   = sw_meta_ff;
      sw_r_in      = sw_r_ff;
      fin_in       = fin_ff;
      fin_kv_in    = fin_kv_ff;
      fin_slot_in  = fin_slot_ff;
      fin_meta_in  = fin_meta_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_CLEAR: begin
            cnt_in = cnt_ff + (AW + 1)'(1);
            if (cnt_ff[AW-1:0] == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               req_in     = req_data;
               cnt_in     = '0;
               m_found_in = 1'b0;
               o_found_in = 1'b0;
               f_found_in = 1'b0;
               state_in   = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (rd_en) begin
               cnt_in = cnt_ff + (AW + 1)'(1);
            end
            if (rv_ff) begin
               // keep the first match of each kind
               if (key_hit && !m_found_ff) begin
                  m_found_in = 1'b1;
                  m_slot_in  = ra_ff;
                  m_pin_in   = rd_p;
                  m_rank_in  = rd_rank;
                  m_val_in   = rd_value;
               end
               if (is_oldest && !o_found_ff) begin
                  o_found_in = 1'b1;
                  o_slot_in  = ra_ff;
                  o_pin_in   = rd_p;
                  o_key_in   = rd_key;
                  o_val_in   = rd_value;
               end
               if (is_free && !f_found_ff) begin
                  f_found_in = 1'b1;
                  f_slot_in  = ra_ff;
               end
               if (ra_ff == LAST_ADDR) begin
                  state_in = ST_DECIDE;
               end
            end
         end
         ST_DECIDE: begin
            st_in     = lkvc_pkg::STAT_MISS;
            ok_in     = '0;
            ov_in     = '0;
            occ_nx_in = occ_ff;
            sw_in     = 1'b0;
            sw_r_in   = '0;
            sw_tgt_in = m_slot_ff;
            sw_meta_in = '0;
            fin_in    = 1'b0;
            fin_kv_in = 1'b0;
            fin_slot_in = f_slot_ff;
            fin_meta_in = {1'b1, 1'b0, AW'(occ_ff)};
            cnt_in    = '0;
            case (req_ff.opcode)
               lkvc_pkg::OP_INSERT: begin
                  if (m_found_ff) begin
                     if (m_pin_ff) begin
                        st_in = lkvc_pkg::STAT_BUSY;
                     end else begin
                        st_in     = lkvc_pkg::STAT_DUP;
                        ok_in     = req_ff.key;
                        ov_in     = m_val_ff;
                        sw_in     = 1'b1;
                        sw_r_in   = m_rank_ff;
                        occ_nx_in = occ_ff - OW'(1);
                     end
                  end else if (full) begin
                     if (!o_found_ff || o_pin_ff) begin
                        st_in = lkvc_pkg::STAT_BUSY;
                     end else begin
                        // evict the oldest, then reuse the lowest free slot
                        st_in       = lkvc_pkg::STAT_EVICTED;
                        ok_in       = o_key_ff;
                        ov_in       = o_val_ff;
                        sw_in       = 1'b1;
                        sw_tgt_in   = o_slot_ff;
                        fin_in      = 1'b1;
                        fin_kv_in   = 1'b1;
                        fin_slot_in = (f_found_ff && (f_slot_ff < o_slot_ff)) ?
                                      f_slot_ff : o_slot_ff;
                        fin_meta_in = {1'b1, 1'b0, AW'(occ_ff - OW'(1))};
                     end
                  end else if (f_found_ff) begin
                     fin_in    = 1'b1;
                     fin_kv_in = 1'b1;
                     occ_nx_in = occ_ff + OW'(1);
                  end
               end
               lkvc_pkg::OP_GET, lkvc_pkg::OP_PIN: begin
                  if (m_found_ff) begin
                     st_in      = lkvc_pkg::STAT_HIT;
                     ov_in      = m_val_ff;
                     sw_in      = 1'b1;
                     sw_r_in    = m_rank_ff;
                     sw_meta_in = {1'b1, m_pin_ff || (req_ff.opcode == lkvc_pkg::OP_PIN),
                                   AW'(occ_ff - OW'(1))};
                  end
               end
               lkvc_pkg::OP_UNPIN: begin
                  if (m_found_ff) begin
                     st_in       = lkvc_pkg::STAT_HIT;
                     ov_in       = m_val_ff;
                     fin_in      = 1'b1;
                     fin_slot_in = m_slot_ff;
                     fin_meta_in = {1'b1, 1'b0, m_rank_ff};
                  end
               end
               lkvc_pkg::OP_REMOVE: begin
                  if (m_found_ff) begin
                     if (m_pin_ff) begin
                        st_in = lkvc_pkg::STAT_BUSY;
                     end else begin
                        st_in     = lkvc_pkg::STAT_HIT;
                        ok_in     = req_ff.key;
                        ov_in     = m_val_ff;
                        sw_in     = 1'b1;
                        sw_r_in   = m_rank_ff;
                        occ_nx_in = occ_ff - OW'(1);
                     end
                  end
               end
               lkvc_pkg::OP_EVICT: begin
                  if ((occ_ff == '0) || !o_found_ff) begin
                     st_in = lkvc_pkg::STAT_EMPTY;
                  end else if (o_pin_ff) begin
                     st_in = lkvc_pkg::STAT_BUSY;
                  end else begin
                     st_in     = lkvc_pkg::STAT_HIT;
                     ok_in     = o_key_ff;
                     ov_in     = o_val_ff;
                     sw_in     = 1'b1;
                     sw_tgt_in = o_slot_ff;
                     occ_nx_in = occ_ff - OW'(1);
                  end
               end
               default: begin
               end
            endcase
            if (sw_in) begin
               state_in = ST_SWEEP;
            end else if (fin_in) begin
               state_in = ST_FINAL;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_SWEEP: begin
            if (rd_en) begin
               cnt_in = cnt_ff + (AW + 1)'(1);
            end
            if (rv_ff && (ra_ff == LAST_ADDR)) begin
               state_in = fin_ff ? ST_FINAL : ST_DONE;
            end
         end
         ST_FINAL: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // hold until the response register is free
            if (rsp_load) begin
               rsp_in.status     = st_ff;
               rsp_in.out_key    = ok_ff;
               rsp_in.out_value  = ov_ff;
               rsp_in.fill_count = lkvc_pkg::FILL_W'(occ_nx_ff);
               rsp_valid_in      = 1'b1;
               occ_in            = occ_nx_ff;
               state_in          = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
         cap_ff       <= lkvc_pkg::CAP_RESET;
         occ_ff       <= '0;
         cnt_ff       <= '0;
         rv_ff        <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cap_ff       <= cap_in;
         occ_ff       <= occ_in;
         cnt_ff       <= cnt_in;
         rv_ff        <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      rsp_ff      <= rsp_in;
      ra_ff       <= ra_in;
      m_found_ff  <= m_found_in;
      m_slot_ff   <= m_slot_in;
      m_pin_ff    <= m_pin_in;
      m_rank_ff   <= m_rank_in;
      m_val_ff    <= m_val_in;
      o_found_ff  <= o_found_in;
      o_slot_ff   <= o_slot_in;
      o_pin_ff    <= o_pin_in;
      o_key_ff    <= o_key_in;
      o_val_ff    <= o_val_in;
      f_found_ff  <= f_found_in;
      f_slot_ff   <= f_slot_in;
      st_ff       <= st_in;
      ok_ff       <= ok_in;
      ov_ff       <= ov_in;
      occ_nx_ff   <= occ_nx_in;
      sw_ff       <= sw_in;
      sw_tgt_ff   <= sw_tgt_in;
      sw_meta_ff  <= sw_meta_in;
      sw_r_ff     <= sw_r_in;
      fin_ff      <= fin_in;
      fin_kv_ff   <= fin_kv_in;
      fin_slot_ff <= fin_slot_in;
      fin_meta_ff <= fin_meta_in;
   end

`ifndef ASSERT_OFF
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      LW'(occ_ff) <= LW'(ENTRIES))
      else $error("occupancy above entry count");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("response posted outside done state");

   a_sweep_no_kv: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SWEEP) |-> !wr_kv_en)
      else $error("key/value write during rank sweep");

   a_occ_only_on_load: assert property (@(posedge clock) disable iff (reset)
      (occ_ff != $past(occ_ff)) |-> $past(rsp_load))
      else $error("occupancy changed without a response");
`endif

endmodule
